### rtl/cpg_pkg.sv
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared widths, op codes and the step job record for the circle point
// generator.
// ----------------------------------------------------------------------------
package cpg_pkg;

  // coordinate widths
  localparam int COORD_WIDTH = 10;
  localparam int Y_WIDTH     = COORD_WIDTH + 1;
  localparam int POINT_WIDTH = COORD_WIDTH + 2;
  // running error x*x + y*y - r*r, signed, with headroom
  localparam int ERR_WIDTH   = 2 * COORD_WIDTH + 4;

  // step job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // points per step and point index width
  localparam int PTS_PER_STEP = 8;
  localparam int IDX_WIDTH    = $clog2(PTS_PER_STEP);

  // item op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // one step: octant position, centre and end-of-circle flag
  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [Y_WIDTH-1:0]     y;
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
    logic                   done;
  } job_t;

endpackage

### rtl/cpg_front.sv
// ----------------------------------------------------------------------------
// cpg_front
// Accepts load and step beats, keeps the circle state and the running
// midpoint error, and queues one job per step of an active circle.
// ----------------------------------------------------------------------------
module cpg_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            op,
  input  logic [cpg_pkg::COORD_WIDTH-1:0] radius,
  input  logic [cpg_pkg::COORD_WIDTH-1:0] center_x,
  input  logic [cpg_pkg::COORD_WIDTH-1:0] center_y,
  output logic                            push,
  output cpg_pkg::job_t                   push_job,
  input  logic                            queue_full
);

  localparam int CW = cpg_pkg::COORD_WIDTH;
  localparam int YW = cpg_pkg::Y_WIDTH;
  localparam int EW = cpg_pkg::ERR_WIDTH;

  logic                 active;
  logic [CW-1:0]        cur_x;
  logic [YW-1:0]        cur_y;
  logic signed [EW-1:0] err;
  logic [CW-1:0]        cx;
  logic [CW-1:0]        cy;

  logic                 accept;
  logic signed [EW-1:0] two_y_p1;
  logic signed [EW-1:0] two_x_m1;
  logic signed [EW-1:0] err_prev;
  logic [EW-1:0]        abs_err;
  logic [EW-1:0]        abs_prev;
  logic                 dec;
  logic signed [EW-1:0] err_next;
  logic signed [YW+1:0] nx;
  logic signed [YW+1:0] ny;
  logic                 done;
  logic [CW-1:0]        cur_x_next;

  // handshake: hold off only when the job queue is full
  assign item_stall = queue_full;
  assign accept     = item_valid && !item_stall;

  // midpoint decision from the running error
  always_comb begin
    two_y_p1 = $signed({{(EW-YW-1){1'b0}}, cur_y, 1'b1});
    two_x_m1 = $signed({{(EW-CW-1){1'b0}}, cur_x, 1'b0}) - $signed(EW'(1));
    err_prev = err - two_y_p1 + $signed(EW'(2));
    abs_err  = err[EW-1] ? $unsigned(-err) : $unsigned(err);
    abs_prev = err_prev[EW-1] ? $unsigned(-err_prev) : $unsigned(err_prev);
    dec      = abs_err > abs_prev;
    err_next = err + two_y_p1 - (dec ? two_x_m1 : $signed(EW'(0)));
    nx       = $signed({{(YW-CW+2){1'b0}}, cur_x}) - $signed((YW+2)'(dec));
    ny       = $signed({2'b00, cur_y}) + $signed((YW+2)'(1));
    done     = ny > nx;
    cur_x_next = nx[YW+1] ? '0 : nx[CW-1:0];
  end

  // job for the back end, taken from the position before the update
  assign push = accept && (op == cpg_pkg::OP_STEP) && active;
  always_comb begin
    push_job.x    = cur_x;
    push_job.y    = cur_y;
    push_job.cx   = cx;
    push_job.cy   = cy;
    push_job.done = done;
  end

  // circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cur_x  <= '0;
      cur_y  <= '0;
      err    <= '0;
      cx     <= '0;
      cy     <= '0;
    end else if (accept && (op == cpg_pkg::OP_LOAD)) begin
      active <= 1'b1;
      cur_x  <= radius;
      cur_y  <= '0;
      err    <= '0;
      cx     <= center_x;
      cy     <= center_y;
    end else if (push) begin
      active <= !done;
      cur_x  <= cur_x_next;
      cur_y  <= ny[YW-1:0];
      err    <= err_next;
    end
  end

endmodule

### rtl/cpg_queue.sv
// ----------------------------------------------------------------------------
// cpg_queue
// Small register queue of step jobs between front and back.
// ----------------------------------------------------------------------------
module cpg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cpg_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output cpg_pkg::job_t head,
  output logic          empty
);

  localparam int QD = cpg_pkg::QUEUE_DEPTH;
  localparam int AW = cpg_pkg::QUEUE_AW;

  cpg_pkg::job_t entries [QD];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(QD);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

### rtl/cpg_back.sv
// ----------------------------------------------------------------------------
// cpg_back
// Walks the eight mirrored points of the job at the queue head, one per
// cycle while point_stall does not hold the output, into the output register.
// ----------------------------------------------------------------------------
module cpg_back (
  input  logic                            clk,
  input  logic                            rst,
  input  cpg_pkg::job_t                   head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            point_valid,
  input  logic                            point_stall,
  output logic [cpg_pkg::POINT_WIDTH-1:0] point_x,
  output logic [cpg_pkg::POINT_WIDTH-1:0] point_y,
  output logic                            last_of_step,
  output logic                            circle_done
);

  localparam int YW = cpg_pkg::Y_WIDTH;
  localparam int PW = cpg_pkg::POINT_WIDTH;
  localparam int IW = cpg_pkg::IDX_WIDTH;

  logic [IW-1:0] idx;
  logic          advance;
  logic          last;
  logic [YW-1:0] off_x;
  logic [YW-1:0] off_y;
  logic [PW-1:0] px;
  logic [PW-1:0] py;

  assign advance = !empty && (!point_valid || !point_stall);
  assign last    = idx == IW'(cpg_pkg::PTS_PER_STEP - 1);
  assign pop     = advance && last;

  // point select: upper half swaps x and y, bit 1 negates column, bit 0 row
  always_comb begin
    off_x = idx[2] ? head.y : {1'b0, head.x};
    off_y = idx[2] ? {1'b0, head.x} : head.y;
    px = idx[1] ? {2'b00, head.cx} - {1'b0, off_x} : {2'b00, head.cx} + {1'b0, off_x};
    py = idx[0] ? {2'b00, head.cy} - {1'b0, off_y} : {2'b00, head.cy} + {1'b0, off_y};
  end

  // point index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      point_valid <= 1'b0;
    end else if (advance) begin
      idx         <= idx + IW'(1);
      point_valid <= 1'b1;
    end else if (!point_stall) begin
      point_valid <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (advance) begin
      point_x      <= px;
      point_y      <= py;
      last_of_step <= last;
      circle_done  <= last && head.done;
    end
  end

endmodule

### rtl/circle_point_generator_unit.sv
// ----------------------------------------------------------------------------
// circle_point_generator_unit
// Midpoint circle rasterizer with eight-way symmetry.
//
// Input channel (item_valid / item_stall): op selects load or step. A load
// beat takes radius, center_x and center_y and starts a new circle; it makes
// no points. A step beat of an active circle queues one job of eight points;
// a step with no active circle is dropped.
// Output channel (point_valid / point_stall): one point per beat, unclipped
// two's complement, last_of_step on the eighth point, circle_done on the
// eighth point of the step that ends the circle.
// The first point of a step passes through the queue write and then the
// output register. Throughput: the single output register drains one point
// a cycle while point_stall is low; the front keeps taking beats while a
// four-entry job queue has room and raises item_stall only when it is full.
// Reset (rst, synchronous) drops the active circle, empties the queue and
// clears point_valid. A stalled output beat holds its payload, and the queue
// then fills behind it.
// ----------------------------------------------------------------------------
module circle_point_generator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            op,
  input  logic [cpg_pkg::COORD_WIDTH-1:0] radius,
  input  logic [cpg_pkg::COORD_WIDTH-1:0] center_x,
  input  logic [cpg_pkg::COORD_WIDTH-1:0] center_y,
  output logic                            point_valid,
  input  logic                            point_stall,
  output logic [cpg_pkg::POINT_WIDTH-1:0] point_x,
  output logic [cpg_pkg::POINT_WIDTH-1:0] point_y,
  output logic                            last_of_step,
  output logic                            circle_done
);

  logic          push;
  cpg_pkg::job_t push_job;
  logic          queue_full;
  logic          pop;
  cpg_pkg::job_t head;
  logic          empty;

  // front: item intake and circle state
  cpg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .radius     (radius),
    .center_x   (center_x),
    .center_y   (center_y),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  // job queue
  cpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // back: point emission
  cpg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule

### test/tb_circle_point_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_circle_point_generator_unit
// Self-checking bench for the midpoint circle point generator.
//
// Load and step beats go in through the item channel. A behavioral model of
// the octant walk predicts the eight mirrored points of every live step, and
// each point beat is checked field by field against the oldest prediction.
// Both channels idle at random. One phase holds the point channel off for a
// long stretch so the job queue fills and the input stalls.
// ----------------------------------------------------------------------------
module tb_circle_point_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [cpg_pkg::COORD_WIDTH-1:0] coord_t;
  typedef logic [cpg_pkg::POINT_WIDTH-1:0] point_t;

  // one predicted point beat
  typedef struct packed {
    point_t px;
    point_t py;
    logic   last;
    logic   fin;
  } plot_pt_t;

  localparam int RUN_ITEMS   = 370;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_LEN    = 300;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_stall;
  logic   op = cpg_pkg::OP_LOAD;
  coord_t radius = '0;
  coord_t center_x = '0;
  coord_t center_y = '0;
  logic   point_valid;
  logic   point_stall = 1'b0;
  point_t point_x;
  point_t point_y;
  logic   last_of_step;
  logic   circle_done;

  circle_point_generator_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .radius       (radius),
    .center_x     (center_x),
    .center_y     (center_y),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

  always #2 clk = ~clk;

  // predicted circle state
  logic                              arc_on  = 1'b0;
  logic [cpg_pkg::COORD_WIDTH-1:0]   arc_x   = '0;
  logic [cpg_pkg::Y_WIDTH-1:0]       arc_y   = '0;
  logic [2*cpg_pkg::COORD_WIDTH-1:0] arc_rsq = '0;
  coord_t                            arc_cx  = '0;
  coord_t                            arc_cy  = '0;

  plot_pt_t plot_queue[$];

  // run bookkeeping
  int  items_sent     = 0;
  int  loads_sent     = 0;
  int  live_steps     = 0;
  int  ignored_steps  = 0;
  int  circles_closed = 0;
  int  points_checked = 0;
  int  err_count      = 0;
  int  cycle_count    = 0;
  bit  sender_idle    = 1'b1;
  bit  receiver_idle  = 1'b1;
  int  hold_request   = 0;

  // ---------------------------------------------------------------------------
  // point prediction
  // ---------------------------------------------------------------------------
  function automatic void push_point(longint px, longint py, logic last, logic fin);
    plot_pt_t p;
    p.px   = px[cpg_pkg::POINT_WIDTH-1:0];
    p.py   = py[cpg_pkg::POINT_WIDTH-1:0];
    p.last = last;
    p.fin  = fin;
    plot_queue.push_back(p);
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // advance the octant walk for one accepted beat
  function automatic void predict_item(logic op_i, coord_t r, coord_t cx, coord_t cy);
    longint x, y, ox, oy, r2, err_here, err_below, nx, ny;
    logic   fin;
    if (op_i == cpg_pkg::OP_LOAD) begin
      r2      = longint'(r) * longint'(r);
      arc_rsq = r2[2*cpg_pkg::COORD_WIDTH-1:0];
      arc_cx  = cx;
      arc_cy  = cy;
      arc_x   = r;
      arc_y   = '0;
      arc_on  = 1'b1;
    end else if (arc_on) begin
      x  = arc_x;
      y  = arc_y;
      ox = arc_cx;
      oy = arc_cy;
      r2 = arc_rsq;
      // pick the pixel closer to the true circle
      err_here  = abs_l(x * x + y * y - r2);
      err_below = abs_l(x * x + (y - 1) * (y - 1) - r2);
      nx  = (err_here > err_below) ? x - 1 : x;
      ny  = y + 1;
      fin = (ny > nx);
      if (nx < 0) nx = 0;
      arc_x = nx[cpg_pkg::COORD_WIDTH-1:0];
      arc_y = ny[cpg_pkg::Y_WIDTH-1:0];
      if (fin) begin
        arc_on = 1'b0;
        circles_closed++;
      end
      // eight-way mirror, fixed order
      push_point(ox + x, oy + y, 1'b0, 1'b0);
      push_point(ox + x, oy - y, 1'b0, 1'b0);
      push_point(ox - x, oy + y, 1'b0, 1'b0);
      push_point(ox - x, oy - y, 1'b0, 1'b0);
      push_point(ox + y, oy + x, 1'b0, 1'b0);
      push_point(ox + y, oy - x, 1'b0, 1'b0);
      push_point(ox - y, oy + x, 1'b0, 1'b0);
      push_point(ox - y, oy - x, 1'b1, fin);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // item driver: one beat, held until taken
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op_i, input coord_t r, input coord_t cx,
                           input coord_t cy);
    int gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= op_i;
    radius     <= r;
    center_x   <= cx;
    center_y   <= cy;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (op_i == cpg_pkg::OP_LOAD) begin
      loads_sent++;
    end else if (arc_on) begin
      live_steps++;
    end else begin
      ignored_steps++;
    end
    predict_item(op_i, r, cx, cy);
  endtask

  // step beat with junk in the unused fields
  task automatic send_step();
    send_item(cpg_pkg::OP_STEP, coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  // load, then step until the circle closes or the budget runs out
  task automatic run_circle(input coord_t r, input coord_t cx, input coord_t cy,
                            input int max_steps);
    int n;
    n = 0;
    send_item(cpg_pkg::OP_LOAD, r, cx, cy);
    while (arc_on && n < max_steps) begin
      send_step();
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // point receiver: random stalls, plus a long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int w;
    forever begin
      if (hold_request > 0) begin
        point_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      w = receiver_idle ? $urandom_range(0, 15) : 0;
      if (w > 0) begin
        point_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      point_stall <= 1'b0;
      do @(posedge clk); while (!point_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // point checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    plot_pt_t e;
    if (!rst && point_valid && !point_stall) begin
      if (plot_queue.size() == 0) begin
        err_count++;
        $display("%0t unexpected point beat x=%0d y=%0d", $time,
                 $signed(point_x), $signed(point_y));
      end else begin
        e = plot_queue.pop_front();
        points_checked++;
        if (point_x !== e.px) begin
          err_count++;
          $display("%0t point_x expected %0d actual %0d", $time,
                   $signed(e.px), $signed(point_x));
        end
        if (point_y !== e.py) begin
          err_count++;
          $display("%0t point_y expected %0d actual %0d", $time,
                   $signed(e.py), $signed(point_y));
        end
        if (last_of_step !== e.last) begin
          err_count++;
          $display("%0t last_of_step expected %0b actual %0b", $time,
                   e.last, last_of_step);
        end
        if (circle_done !== e.fin) begin
          err_count++;
          $display("%0t circle_done expected %0b actual %0b", $time,
                   e.fin, circle_done);
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d points outstanding", $time, plot_queue.size());
      $display("tb_circle_point_generator_unit: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // steps with no circle loaded make no points
  task automatic test_idle_steps();
    send_item(cpg_pkg::OP_STEP, '1, '1, '1);
    send_item(cpg_pkg::OP_STEP, '0, '0, '0);
  endtask

  // zero radius: one step of eight centre copies closes the circle
  task automatic test_zero_radius();
    run_circle('0, '0, '0, 4);
    send_step();
    run_circle('0, '1, '1, 4);
  endtask

  // full-scale radius at the corners, abandoned by a new load; tiny circles
  task automatic test_extremes();
    run_circle('1, '0, '0, 2);
    run_circle('1, '1, '1, 2);
    run_circle(coord_t'(1), coord_t'(512), coord_t'(512), 100);
    run_circle(coord_t'(3), '1, '0, 100);
    send_step();
  endtask

  // hold the point channel while steps keep coming, so the input stalls
  task automatic test_back_pressure();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_request  = HOLD_LEN;
    run_circle(coord_t'(20), coord_t'($urandom), coord_t'($urandom), 10);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // mostly whole small circles, some big ones cut short, some noise
  task automatic test_random_circles();
    int kind, mode;
    while (items_sent < RUN_ITEMS) begin
      kind = $urandom_range(0, 99);
      mode = $urandom_range(0, 3);
      sender_idle   = (mode != 0) && (mode != 1);
      receiver_idle = (mode != 0) && (mode != 2);
      if (kind < 70) begin
        run_circle(coord_t'($urandom_range(0, 24)), coord_t'($urandom),
                   coord_t'($urandom), 1000);
        if ($urandom_range(0, 4) == 0) send_step();
      end else if (kind < 88) begin
        run_circle(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   $urandom_range(1, 8));
      end else if (kind < 95) begin
        send_step();
      end else begin
        send_item(cpg_pkg::OP_LOAD, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
      end
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_steps();
    test_zero_radius();
    test_extremes();
    test_back_pressure();
    test_random_circles();

    item_valid <= 1'b0;
    while (plot_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run: %0d loads, %0d live steps, %0d ignored steps, %0d circles closed",
             loads_sent, live_steps, ignored_steps, circles_closed);
    $display("run: %0d points checked, %0d mismatches, %0d cycles",
             points_checked, err_count, cycle_count);
    if (err_count == 0) begin
      $display("tb_circle_point_generator_unit: PASS");
    end else begin
      $display("tb_circle_point_generator_unit: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cpg_pkg.sv
rtl/cpg_front.sv
rtl/cpg_queue.sv
rtl/cpg_back.sv
rtl/circle_point_generator_unit.sv
test/tb_circle_point_generator_unit.sv
